// File: hdl/smo_pkg.sv
// Shared constants, types and helper functions of the smoothed multiwave oscillator.
`default_nettype none
package smo_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_BITS     = 16;

    localparam int MW    = 33;
    localparam int PW    = 2 * MW;
    localparam int QBITS = SINE_TABLE_BITS - 2;
    localparam int WQ    = 18;

    localparam int WAVE_MAX_I = (2 ** (SAMPLE_BITS - 1)) - 1;
    localparam int WAVE_MIN_I = -(2 ** (SAMPLE_BITS - 1));

    localparam logic [18:0] FREQ_MIN      = 19'd320;
    localparam logic [18:0] FREQ_MAX      = 19'd320000;
    localparam logic [15:0] AMP_MAX       = 16'd32768;
    localparam logic [31:0] AMP_THRESHOLD = 32'd2148;
    localparam logic [31:0] DEFAULT_SEED  = 32'h12345678;

    localparam logic [31:0] RST_PHASE_STEP = 32'd1431655;
    localparam logic [15:0] RST_GAIN       = 16'd273;
    localparam logic [31:0] RST_FREQ       = 32'd57671680;
    localparam logic [31:0] RST_AMP        = 32'd1073741824;

    localparam logic signed [MW-1:0] GAUSS_K     = 33'sd28378;
    localparam logic signed [MW-1:0] SA1         = 33'sd1686629713;
    localparam logic signed [MW-1:0] SA3         = 33'sd693598668;
    localparam logic signed [MW-1:0] SA5         = 33'sd85569306;
    localparam logic signed [MW-1:0] SA7         = 33'sd5026995;
    localparam logic signed [MW-1:0] SA9         = 33'sd172272;
    localparam logic signed [MW-1:0] DIRECT_FEED = 33'sd8995943;
    localparam logic signed [MW-1:0] P6_FEED     = 33'sd1944916;
    localparam logic signed [MW-1:0] PINK_SCALE  = 33'sd1845494;

    localparam logic [2:0] LAST_POLE = 3'd5;

    typedef logic [2:0] t_wave;
    localparam t_wave WAVE_NONE  = 3'd0;
    localparam t_wave WAVE_SIN   = 3'd1;
    localparam t_wave WAVE_SQR   = 3'd2;
    localparam t_wave WAVE_RAMP  = 3'd3;
    localparam t_wave WAVE_TRI   = 3'd4;
    localparam t_wave WAVE_WHITE = 3'd5;
    localparam t_wave WAVE_PINK  = 3'd6;

    localparam logic [1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [1:0] CFG_GAIN       = 2'd1;
    localparam logic [1:0] CFG_SEED       = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_FREQ, ST_AMP, ST_AUPD, ST_PHASE,
        ST_SIN_A, ST_SIN_B, ST_SIN_C, ST_SIN_D, ST_SIN_E, ST_SIN_F, ST_SIN_G,
        ST_SHAPE, ST_NOISE, ST_GAUSS,
        ST_PK_A, ST_PK_B, ST_PK_C, ST_PK_DIR, ST_PK_SUM, ST_PK_P6, ST_PK_OUT,
        ST_OUT_MUL, ST_OUT_WR
    } t_step;

    typedef struct packed {
        t_step      step;
        logic       load;
        logic       amp_zero;
        t_wave      wave;
        logic [2:0] idx;
    } t_cmd;

    typedef struct packed {
        logic amp_low;
        logic out_free;
    } t_stat;

    function automatic logic signed [MW-1:0] pole_gain(input logic [2:0] idx);
        logic signed [MW-1:0] g;
        case (idx)
            3'd0:    g = 33'sd16758090;
            3'd1:    g = 33'sd16665144;
            3'd2:    g = 33'sd16257122;
            3'd3:    g = 33'sd14537458;
            3'd4:    g = 33'sd9227469;
            3'd5:    g = -33'sd12777528;
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic logic signed [MW-1:0] pole_feed(input logic [2:0] idx);
        logic signed [MW-1:0] f;
        case (idx)
            3'd0:    f = 33'sd931436;
            3'd1:    f = 33'sd1259565;
            3'd2:    f = 33'sd2581208;
            3'd3:    f = 33'sd5209084;
            3'd4:    f = 33'sd8941454;
            3'd5:    f = -33'sd283501;
            default: f = '0;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] xorshift(input logic [31:0] v);
        logic [31:0] x;
        x = v ^ (v << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage
`default_nettype wire

// File: hdl/smo_controller.sv
// Sequencer that walks one sample tick through the shared-multiplier datapath.
`default_nettype none
module smo_controller import smo_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_wave_request,
    input  t_wave i_wave_choice,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_FREQ, S_AMP, S_AUPD, S_PHASE,
        S_SIN_A, S_SIN_B, S_SIN_C, S_SIN_D, S_SIN_E, S_SIN_F, S_SIN_G,
        S_SHAPE, S_NOISE, S_GAUSS,
        S_PK_A, S_PK_B, S_PK_C, S_PK_DIR, S_PK_SUM, S_PK_P6, S_PK_OUT,
        S_OUT_MUL, S_OUT_WR
    } t_state;

    t_state     r_state;
    t_wave      r_cur;
    logic       r_pend;
    t_wave      r_pwave;
    logic [2:0] r_idx;
    t_wave      n_cur;
    logic       n_take;

    // wave that is in use once this tick's fade check is done
    always_comb begin
        n_take = r_pend && i_stat.amp_low;
        n_cur  = n_take ? r_pwave : r_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= WAVE_SIN;
            r_pend  <= 1'b0;
            r_pwave <= WAVE_NONE;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_wave_request && (i_wave_choice <= WAVE_PINK)
                            && (i_wave_choice != r_cur)) begin
                            r_pend  <= 1'b1;
                            r_pwave <= i_wave_choice;
                        end
                        r_state <= S_FREQ;
                    end
                end
                S_FREQ:  r_state <= S_AMP;
                S_AMP:   r_state <= S_AUPD;
                S_AUPD:  r_state <= S_PHASE;
                S_PHASE: begin
                    if (n_take) begin
                        r_cur  <= r_pwave;
                        r_pend <= 1'b0;
                    end
                    case (n_cur)
                        WAVE_SIN:               r_state <= S_SIN_A;
                        WAVE_WHITE, WAVE_PINK:  r_state <= S_NOISE;
                        default:                r_state <= S_SHAPE;
                    endcase
                end
                S_SIN_A: r_state <= S_SIN_B;
                S_SIN_B: r_state <= S_SIN_C;
                S_SIN_C: r_state <= S_SIN_D;
                S_SIN_D: r_state <= S_SIN_E;
                S_SIN_E: r_state <= S_SIN_F;
                S_SIN_F: r_state <= S_SIN_G;
                S_SIN_G: r_state <= S_OUT_MUL;
                S_SHAPE: r_state <= S_OUT_MUL;
                S_NOISE: r_state <= S_GAUSS;
                S_GAUSS: begin
                    r_idx   <= '0;
                    r_state <= (r_cur == WAVE_PINK) ? S_PK_A : S_OUT_MUL;
                end
                S_PK_A:  r_state <= S_PK_B;
                S_PK_B:  r_state <= S_PK_C;
                S_PK_C: begin
                    if (r_idx == LAST_POLE) begin
                        r_state <= S_PK_DIR;
                    end else begin
                        r_idx   <= r_idx + 3'd1;
                        r_state <= S_PK_A;
                    end
                end
                S_PK_DIR:  r_state <= S_PK_SUM;
                S_PK_SUM:  r_state <= S_PK_P6;
                S_PK_P6:   r_state <= S_PK_OUT;
                S_PK_OUT:  r_state <= S_OUT_MUL;
                S_OUT_MUL: r_state <= S_OUT_WR;
                S_OUT_WR: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.amp_zero = r_pend;
        o_cmd.wave     = r_cur;
        o_cmd.idx      = r_idx;
        unique case (r_state)
            S_IDLE:    o_cmd.step = ST_IDLE;
            S_FREQ:    o_cmd.step = ST_FREQ;
            S_AMP:     o_cmd.step = ST_AMP;
            S_AUPD:    o_cmd.step = ST_AUPD;
            S_PHASE:   o_cmd.step = ST_PHASE;
            S_SIN_A:   o_cmd.step = ST_SIN_A;
            S_SIN_B:   o_cmd.step = ST_SIN_B;
            S_SIN_C:   o_cmd.step = ST_SIN_C;
            S_SIN_D:   o_cmd.step = ST_SIN_D;
            S_SIN_E:   o_cmd.step = ST_SIN_E;
            S_SIN_F:   o_cmd.step = ST_SIN_F;
            S_SIN_G:   o_cmd.step = ST_SIN_G;
            S_SHAPE:   o_cmd.step = ST_SHAPE;
            S_NOISE:   o_cmd.step = ST_NOISE;
            S_GAUSS:   o_cmd.step = ST_GAUSS;
            S_PK_A:    o_cmd.step = ST_PK_A;
            S_PK_B:    o_cmd.step = ST_PK_B;
            S_PK_C:    o_cmd.step = ST_PK_C;
            S_PK_DIR:  o_cmd.step = ST_PK_DIR;
            S_PK_SUM:  o_cmd.step = ST_PK_SUM;
            S_PK_P6:   o_cmd.step = ST_PK_P6;
            S_PK_OUT:  o_cmd.step = ST_PK_OUT;
            S_OUT_MUL: o_cmd.step = ST_OUT_MUL;
            S_OUT_WR:  o_cmd.step = ST_OUT_WR;
            default:   o_cmd.step = ST_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
`default_nettype wire

// File: hdl/smo_datapath.sv
// Datapath: oscillator state, shared 33x33 multiplier, wave shaping and output word register.
`default_nettype none
module smo_datapath import smo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic [18:0] i_target_freq,
    input  logic [15:0] i_amp_goal,
    input  logic        i_out_ready,
    output t_stat       o_stat,
    output logic        o_out_valid,
    output logic [15:0] o_sample,
    output t_wave       o_active_wave
);

    localparam int SB   = SAMPLE_BITS;
    localparam int Q_UP = (SB >= 17) ? SB - 17 : 0;
    localparam int Q_DN = (SB >= 17) ? 0 : 17 - SB;
    localparam logic [QBITS:0] QUARTER = (QBITS + 1)'(2 ** QBITS);
    localparam logic signed [PW-1:0] SIN_RND = PW'(2 ** (30 - SB));
    localparam logic signed [PW-1:0] OUT_RND = PW'(1) <<< (SB + 14);
    localparam logic signed [PW-1:0] P_WMAX  = PW'(WAVE_MAX_I);
    localparam logic signed [PW-1:0] P_WMIN  = PW'(WAVE_MIN_I);
    localparam logic signed [PW-1:0] POLE_HI = PW'(8388607);
    localparam logic signed [PW-1:0] POLE_LO = PW'(-8388608);
    localparam logic signed [PW-1:0] S16_HI  = PW'(32767);
    localparam logic signed [PW-1:0] S16_LO  = PW'(-32768);

    logic [31:0] r_step;
    logic [15:0] r_gain;
    logic [31:0] r_lfsr;
    logic [31:0] r_freq;
    logic [31:0] r_amp;
    logic [31:0] r_phase;
    logic signed [23:0] r_pole [7];
    logic        r_ovalid;

    logic [18:0] r_tf;
    logic [15:0] r_ta;
    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] r_acc;
    logic signed [MW-1:0] r_x2;
    logic signed [WQ-1:0] r_w;
    logic signed [SB-1:0] r_wave;
    logic [15:0] r_osample;
    t_wave       r_owave;

    logic signed [MW-1:0] n_ma, n_mb;

    logic signed [PW-1:0] w_q16, w_q24, w_q30;
    logic signed [MW-1:0] w_p30;
    logic signed [MW-1:0] w_freq, w_amp, w_gain, w_tgt_f, w_tgt_a, w_x, w_wext;
    logic [SINE_TABLE_BITS-1:0] w_sidx;
    logic [1:0]  w_quad;
    logic [QBITS:0] w_pos;
    logic signed [PW-1:0] w_sr;
    logic signed [SB-1:0] w_sine;
    logic [31:0] w_r1, w_r2, w_r3, w_r4;
    logic [25:0] w_gsum;
    logic signed [MW-1:0] w_gc;
    logic signed [33:0] w_td;
    logic [32:0] w_tabs;
    logic signed [SB-1:0] w_shape;
    logic signed [PW-1:0] w_psum, w_pv, w_fin;
    logic [15:0] w_sample;
    logic [18:0] w_tf_sat;
    logic [15:0] w_ta_sat;

    function automatic logic signed [SB-1:0] clamp_wave(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        t = v;
        if (t > P_WMAX) t = P_WMAX;
        if (t < P_WMIN) t = P_WMIN;
        return $signed(t[SB-1:0]);
    endfunction

    function automatic logic signed [SB-1:0] to_wave(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        t = (v <<< Q_UP) >>> Q_DN;
        return clamp_wave(t);
    endfunction

    function automatic logic signed [23:0] sat_pole(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        t = v;
        if (t > POLE_HI) t = POLE_HI;
        if (t < POLE_LO) t = POLE_LO;
        return $signed(t[23:0]);
    endfunction

    // input saturation
    always_comb begin
        w_tf_sat = i_target_freq;
        if (w_tf_sat < FREQ_MIN) w_tf_sat = FREQ_MIN;
        if (w_tf_sat > FREQ_MAX) w_tf_sat = FREQ_MAX;
        w_ta_sat = (i_amp_goal > AMP_MAX) ? AMP_MAX : i_amp_goal;
    end

    always_comb begin
        w_q16  = r_prod >>> 16;
        w_q24  = r_prod >>> 24;
        w_q30  = r_prod >>> 30;
        w_p30  = $signed(w_q30[MW-1:0]);
        w_freq = $signed({1'b0, r_freq});
        w_amp  = $signed({1'b0, r_amp});
        w_gain = $signed({17'd0, r_gain});
        w_tgt_f = $signed({1'b0, r_tf, 13'd0});
        w_tgt_a = i_cmd.amp_zero ? '0 : $signed({1'b0, r_ta, 16'd0});
        w_wext = MW'(r_w);
    end

    // quarter-wave sine argument
    always_comb begin
        w_sidx = r_phase[31 -: SINE_TABLE_BITS];
        w_quad = w_sidx[SINE_TABLE_BITS-1 -: 2];
        w_pos  = w_quad[0] ? (QUARTER - {1'b0, w_sidx[QBITS-1:0]})
                           : {1'b0, w_sidx[QBITS-1:0]};
        w_x    = $signed({{(MW-31){1'b0}}, w_pos, {(30-QBITS){1'b0}}});
        w_sr   = (w_q30 + SIN_RND) >>> (31 - SB);
        if (w_sr < 0) w_sr = '0;
        if (w_sr > P_WMAX) w_sr = P_WMAX;
        w_sine = w_quad[1] ? -$signed(w_sr[SB-1:0]) : $signed(w_sr[SB-1:0]);
    end

    // four uniforms, summed and centered
    always_comb begin
        w_r1   = xorshift(r_lfsr);
        w_r2   = xorshift(w_r1);
        w_r3   = xorshift(w_r2);
        w_r4   = xorshift(w_r3);
        w_gsum = 26'(w_r1[31:8]) + 26'(w_r2[31:8]) + 26'(w_r3[31:8]) + 26'(w_r4[31:8]);
        w_gc   = $signed({7'd0, w_gsum}) - 33'sd33554432;
    end

    // square, saw, triangle
    always_comb begin
        w_td   = $signed({2'b00, r_phase}) - 34'sd2147483648;
        w_tabs = w_td[33] ? 33'(-w_td) : w_td[32:0];
        case (i_cmd.wave)
            WAVE_SQR:  w_shape = r_phase[31] ? SB'(WAVE_MIN_I) : SB'(WAVE_MAX_I);
            WAVE_RAMP: w_shape = $signed({~r_phase[31], r_phase[30 -: SB-1]});
            WAVE_TRI:  w_shape = clamp_wave($signed(PW'(w_tabs >> (31 - SB))) + P_WMIN);
            default:   w_shape = '0;
        endcase
    end

    always_comb begin
        w_psum = w_q24;
        for (int i = 0; i < 7; i++) begin
            w_psum = w_psum + PW'(r_pole[i]);
        end
        w_pv  = r_acc + r_prod;
        w_fin = (r_prod + OUT_RND) >>> (SB + 15);
        if (w_fin > S16_HI) w_fin = S16_HI;
        if (w_fin < S16_LO) w_fin = S16_LO;
        w_sample = w_fin[15:0];
    end

    // operand select of the shared multiplier
    always_comb begin
        n_ma = '0;
        n_mb = '0;
        case (i_cmd.step)
            ST_FREQ: begin
                n_ma = w_tgt_f - w_freq;
                n_mb = w_gain;
            end
            ST_AMP: begin
                n_ma = w_tgt_a - w_amp;
                n_mb = w_gain;
            end
            ST_AUPD: begin
                n_ma = w_freq;
                n_mb = $signed({1'b0, r_step});
            end
            ST_SIN_A: begin
                n_ma = w_x;
                n_mb = w_x;
            end
            ST_SIN_B: begin
                n_ma = SA9;
                n_mb = w_p30;
            end
            ST_SIN_C: begin
                n_ma = w_p30 - SA7;
                n_mb = r_x2;
            end
            ST_SIN_D: begin
                n_ma = w_p30 + SA5;
                n_mb = r_x2;
            end
            ST_SIN_E: begin
                n_ma = w_p30 - SA3;
                n_mb = r_x2;
            end
            ST_SIN_F: begin
                n_ma = w_p30 + SA1;
                n_mb = w_x;
            end
            ST_NOISE: begin
                n_ma = w_gc;
                n_mb = GAUSS_K;
            end
            ST_PK_A: begin
                n_ma = pole_gain(i_cmd.idx);
                n_mb = MW'(r_pole[i_cmd.idx]);
            end
            ST_PK_B: begin
                n_ma = pole_feed(i_cmd.idx);
                n_mb = w_wext;
            end
            ST_PK_DIR: begin
                n_ma = w_wext;
                n_mb = DIRECT_FEED;
            end
            ST_PK_SUM: begin
                n_ma = w_wext;
                n_mb = P6_FEED;
            end
            ST_PK_P6: begin
                n_ma = $signed(r_acc[MW-1:0]);
                n_mb = PINK_SCALE;
            end
            ST_OUT_MUL, ST_OUT_WR: begin
                n_ma = MW'(r_wave);
                n_mb = w_amp;
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= RST_PHASE_STEP;
            r_gain   <= RST_GAIN;
            r_lfsr   <= DEFAULT_SEED;
            r_freq   <= RST_FREQ;
            r_amp    <= RST_AMP;
            r_phase  <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 7; i++) begin
                r_pole[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PHASE_STEP: r_step <= i_cfg_data;
                    CFG_GAIN:       r_gain <= i_cfg_data[15:0];
                    CFG_SEED:       r_lfsr <= (i_cfg_data != '0) ? i_cfg_data : DEFAULT_SEED;
                    default:        ;
                endcase
            end
            // load a finished word, or drop the one just taken
            if ((i_cmd.step == ST_OUT_WR) && (!r_ovalid || i_out_ready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd.step)
                ST_AMP:    r_freq  <= r_freq + w_q16[31:0];
                ST_AUPD:   r_amp   <= r_amp + w_q16[31:0];
                ST_PHASE:  r_phase <= r_phase + r_prod[52:21];
                ST_NOISE:  r_lfsr  <= w_r4;
                ST_PK_C:   r_pole[i_cmd.idx] <= sat_pole(w_pv >>> 24);
                ST_PK_P6:  r_pole[6] <= sat_pole(w_q24);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_ma * n_mb;
        if (i_cmd.load) begin
            r_tf <= w_tf_sat;
            r_ta <= w_ta_sat;
        end
        case (i_cmd.step)
            ST_SIN_B:  r_x2   <= w_p30;
            ST_SIN_G:  r_wave <= w_sine;
            ST_SHAPE:  r_wave <= w_shape;
            ST_GAUSS: begin
                r_w    <= $signed(w_q24[WQ-1:0]);
                r_wave <= to_wave(w_q24);
            end
            ST_PK_B:   r_acc  <= r_prod;
            ST_PK_SUM: r_acc  <= w_psum;
            ST_PK_OUT: r_wave <= to_wave(w_q24);
            ST_OUT_WR: begin
                if (!r_ovalid || i_out_ready) begin
                    r_osample <= w_sample;
                    r_owave   <= i_cmd.wave;
                end
            end
            default: ;
        endcase
    end

    assign o_stat.amp_low  = (r_amp < AMP_THRESHOLD);
    assign o_stat.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid     = r_ovalid;
    assign o_sample        = r_osample;
    assign o_active_wave   = r_owave;

endmodule
`default_nettype wire

// File: hdl/smoothed_multiwave_oscillator.sv
// Top level of the smoothed multiwave oscillator: controller, datapath and port packing.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tdata: target_freq, amp_goal; tuser: request, choice
//  m_axis    out  m_axis_tvalid/tready    tdata: sample_out; tuser: active_wave
//  cfg       in   i_cfg_we                i_cfg_index, i_cfg_data
//
// One input word is taken at a time; the single shared 33x33 multiplier sets the cycle count.
// Per word: smoothing, phase, the wave's own steps, then output scaling and the write.
// A finished word waits in the output register, so the next input word is taken meanwhile;
// the sequencer stalls only when a new result finds the previous one still untaken.
// Synchronous active-low reset restores the documented power-up state.
`default_nettype none
module smoothed_multiwave_oscillator import smo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [18:0] target_freq, [34:19] amp_goal, [39:35] zero
    input  logic [3:0]  s_axis_tuser,  // [0] wave_request, [3:1] wave_choice
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [15:0] sample_out
    output logic [2:0]  m_axis_tuser,  // [2:0] active_wave
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // control: wave selection, fade handshake and step order
    smo_controller u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .i_wave_request (s_axis_tuser[0]),
        .i_wave_choice  (s_axis_tuser[3:1]),
        .i_stat         (w_stat),
        .o_in_ready     (s_axis_tready),
        .o_cmd          (w_cmd)
    );

    // arithmetic: smoothing, phase, wave generation and amplitude scaling
    smo_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_target_freq (s_axis_tdata[18:0]),
        .i_amp_goal    (s_axis_tdata[34:19]),
        .i_out_ready   (m_axis_tready),
        .o_stat        (w_stat),
        .o_out_valid   (m_axis_tvalid),
        .o_sample      (m_axis_tdata),
        .o_active_wave (m_axis_tuser)
    );

    // hold off input in the cycle after each accepted word
    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while previous word in work");

    // silent wave must give a zero sample
    a_none_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == WAVE_NONE)) |-> (m_axis_tdata == 16'd0))
        else $error("nonzero sample with no wave active");

    // no result shows up right after an accept made while the output is empty
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result appeared too early");

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the smoothed multiwave oscillator: streams sample ticks, predicts each sample.
`default_nettype none
module tb_top;
    import smo_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Bit-exact model of one tick: saturate, smooth, fade-and-swap, advance phase, shape, scale.
    class osc_scoreboard;
        logic [31:0] step_per_hz;
        logic [15:0] gain;
        logic [31:0] sm_freq, sm_amp, phase, lfsr;
        t_wave       cur_wave, pend_wave;
        logic        pending;
        longint      poles[7];
        logic [15:0] want_sample[$];
        t_wave       want_wave[$];
        int          errors;

        function new();
            int i;
            step_per_hz = RST_PHASE_STEP;
            gain = RST_GAIN;
            sm_freq = RST_FREQ;
            sm_amp = RST_AMP;
            phase = 0;
            cur_wave = WAVE_SIN;
            pend_wave = WAVE_NONE;
            pending = 0;
            lfsr = 32'd305419896;
            for (i = 0; i < 7; i++) poles[i] = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                CFG_PHASE_STEP: step_per_hz = val;
                CFG_GAIN:       gain = val[15:0];
                CFG_SEED:       lfsr = (val != 0) ? val : DEFAULT_SEED;
                default: ;
            endcase
        endfunction

        // floor division by 2^s
        function longint fdiv(longint v, int s);
            return v >>> s;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function logic [31:0] glide(logic [31:0] cur, logic [31:0] tgt);
            longint d;
            d = longint'(tgt) - longint'(cur);
            return 32'(longint'(cur) + fdiv(d * longint'(gain), 16));
        endfunction

        function logic [31:0] rnd();
            lfsr = lfsr ^ (lfsr << 13);
            lfsr = lfsr ^ (lfsr >> 17);
            lfsr = lfsr ^ (lfsr << 5);
            return lfsr;
        endfunction

        function longint gauss();
            longint sum;
            int i;
            sum = 0;
            for (i = 0; i < 4; i++) sum += longint'(rnd() >> 8);
            return fdiv((sum - (64'sd1 <<< 25)) * 28378, 24);
        endfunction

        function longint to_wave(longint v);
            return clip(fdiv(v, 1), WAVE_MIN_I, WAVE_MAX_I);
        endfunction

        function longint sine(logic [31:0] ph);
            logic [9:0] idx;
            logic [1:0] quad;
            longint pos, x, x2, p, s;
            idx = ph[31:22];
            quad = idx[9:8];
            pos = idx[7:0];
            if (quad[0]) pos = 256 - pos;
            x = pos <<< 22;
            x2 = fdiv(x * x, 30);
            p = 172272;
            p = fdiv(p * x2, 30) - 5026995;
            p = fdiv(p * x2, 30) + 85569306;
            p = fdiv(p * x2, 30) - 693598668;
            p = fdiv(p * x2, 30) + 1686629713;
            s = fdiv(p * x, 30);
            s = fdiv(s + (64'sd1 <<< 14), 15);
            s = clip(s, 0, WAVE_MAX_I);
            return quad[1] ? -s : s;
        endfunction

        function longint pink();
            longint w, sum;
            longint pg[5], pf[5];
            int i;
            pg = '{16758090, 16665144, 16257122, 14537458, 9227469};
            pf = '{931436, 1259565, 2581208, 5209084, 8941454};
            w = gauss();
            for (i = 0; i < 5; i++)
                poles[i] = clip(fdiv(pg[i] * poles[i] + pf[i] * w, 24), -8388608, 8388607);
            poles[5] = clip(fdiv(-64'sd12777528 * poles[5] - 64'sd283501 * w, 24),
                            -8388608, 8388607);
            sum = fdiv(w * 8995943, 24);
            for (i = 0; i < 7; i++) sum += poles[i];
            poles[6] = clip(fdiv(w * 1944916, 24), -8388608, 8388607);
            return fdiv(sum * 1845494, 24);
        endfunction

        function void note_tick(logic [18:0] tf, logic [15:0] ta, logic req, t_wave choice);
            logic [31:0] amp_tgt;
            logic [63:0] prod;
            longint w, s, d;
            if (tf < FREQ_MIN) tf = FREQ_MIN;
            if (tf > FREQ_MAX) tf = FREQ_MAX;
            if (ta > AMP_MAX) ta = AMP_MAX;
            if (req && choice <= WAVE_PINK && choice != cur_wave) begin
                pending = 1;
                pend_wave = choice;
            end
            amp_tgt = pending ? 32'd0 : {ta, 16'd0};
            sm_freq = glide(sm_freq, {tf, 13'd0});
            sm_amp = glide(sm_amp, amp_tgt);
            if (pending && sm_amp < AMP_THRESHOLD) begin
                pending = 0;
                cur_wave = pend_wave;
            end
            prod = 64'(sm_freq) * 64'(step_per_hz);
            phase = phase + prod[52:21];
            case (cur_wave)
                WAVE_SIN:   w = sine(phase);
                WAVE_SQR:   w = phase < 32'h80000000 ? WAVE_MAX_I : WAVE_MIN_I;
                WAVE_RAMP:  w = longint'(phase[31:16]) + WAVE_MIN_I;
                WAVE_TRI: begin
                    d = longint'(phase) - 64'sh80000000;
                    if (d < 0) d = -d;
                    w = clip((d >>> 15) + WAVE_MIN_I, WAVE_MIN_I, WAVE_MAX_I);
                end
                WAVE_WHITE: w = to_wave(gauss());
                WAVE_PINK:  w = to_wave(pink());
                default:    w = 0;
            endcase
            s = fdiv(w * longint'(sm_amp) + (64'sd1 <<< 30), 31);
            s = clip(s, -32768, 32767);
            want_sample.push_back(16'(s));
            want_wave.push_back(cur_wave);
        endfunction

        function void check_sample(logic [15:0] got_s, logic [2:0] got_w);
            if (want_sample.size() == 0) begin
                $error("unexpected output word sample_out=%0h", got_s);
                errors++;
                return;
            end
            if (want_sample[0] !== got_s) begin
                $error("sample_out exp %0d got %0d", $signed(want_sample[0]), $signed(got_s));
                errors++;
            end
            if (want_wave[0] !== got_w) begin
                $error("active_wave exp %0d got %0d", want_wave[0], got_w);
                errors++;
            end
            void'(want_sample.pop_front());
            void'(want_wave.pop_front());
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // [18:0] target_freq, [34:19] amp_goal
    logic [3:0]  s_axis_tuser = '0;  // [0] wave_request, [3:1] wave_choice
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [15:0] m_axis_tdata;       // [15:0] sample_out
    logic [2:0]  m_axis_tuser;       // [2:0] active_wave
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    osc_scoreboard board = new();
    int          idle_cycles = 0;
    int          burst_left = 0;
    localparam int WATCHDOG = 20000;

    smoothed_multiwave_oscillator u_top (.*);

    initial forever #2 i_clk = ~i_clk;

    // Receiver: stalls in stretches, with long free-running spells mixed in.
    int rx_mode = 0;
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) board.check_sample(m_axis_tdata, m_axis_tuser);
        if ($urandom_range(0, 63) == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ($urandom_range(0, 1) == 0);
        endcase
    end

    // Watchdog: no accepted word on either side for too long ends the run.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("** smoothed_multiwave_oscillator: FAILED **");
            $finish;
        end
    end

    // Send one tick; gap between bursts of random length.
    task automatic send_tick(logic [18:0] tf, logic [15:0] ta, logic req, logic [2:0] ch);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, ta, tf};
        s_axis_tuser <= {ch, req};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_tick(tf, ta, req, t_wave'(ch));
        burst_left--;
    endtask

    // Drain: wait for all expected words, then allow the block to settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (board.want_sample.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // One write, then a wait with the enable low, so it drops before the next write.
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Random tick: mostly in-range targets, occasional wave requests incl. code 7.
    task automatic random_tick(int req_odds);
        logic [18:0] tf;
        logic [15:0] ta;
        tf = ($urandom_range(0, 9) == 0) ? 19'($urandom) : 19'($urandom_range(320, 320000));
        ta = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
        send_tick(tf, ta, $urandom_range(0, req_odds) == 0, 3'($urandom_range(0, 7)));
    endtask

    initial begin
        int i, ph;
        logic [31:0] steps[4];
        logic [15:0] gains[4];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, every wave, request for current, code 7, replace.
        send_tick(19'd0, 16'd0, 1'b0, 3'd0);
        send_tick(19'h7FFFF, 16'hFFFF, 1'b1, 3'd7);
        send_tick(19'd320000, 16'd32768, 1'b1, 3'd1);
        send_tick(19'd320, 16'd32768, 1'b0, 3'd0);
        drain();
        write_reg(CFG_GAIN, 32'h0000FFFF);
        write_reg(CFG_SEED, 32'd0);
        for (i = 0; i <= 7; i++) begin
            send_tick(19'd8000, 16'h7FFF, 1'b1, 3'(i));
            send_tick(19'd8000, 16'h8000, 1'b1, 3'((i + 3) % 8));
            send_tick(19'd8000, 16'h8000, 1'b0, 3'd0);
        end
        drain();
        write_reg(CFG_GAIN, 32'd0);  // frozen: a change stays pending
        send_tick(19'd1000, 16'd100, 1'b1, 3'd2);
        send_tick(19'd1000, 16'd100, 1'b0, 3'd0);
        drain();

        steps = '{32'd1431655, 32'hFFFFFFFF, 32'd0, 32'h00800000};
        gains = '{16'd273, 16'hFFFF, 16'd8000, 16'd30000};
        for (ph = 0; ph < 8; ph++) begin
            write_reg(CFG_PHASE_STEP, ph < 4 ? steps[ph] : $urandom);
            write_reg(CFG_GAIN, ph < 4 ? 32'(gains[ph]) : 32'($urandom_range(1, 65535)));
            write_reg(CFG_SEED, ph == 2 ? 32'hFFFFFFFF : $urandom);
            for (i = 0; i < 175; i++) begin
                random_tick(ph == 0 ? 60 : 15);
                if (i == 90 && ph == 3) drain();
            end
            drain();
        end

        if (board.errors == 0 && board.want_sample.size() == 0)
            $display("** smoothed_multiwave_oscillator: PASSED **");
        else
            $display("** smoothed_multiwave_oscillator: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
hdl/smo_pkg.sv
hdl/smo_controller.sv
hdl/smo_datapath.sv
hdl/smoothed_multiwave_oscillator.sv
bench/tb_top.sv
